// File: hw/rtl/lppm_pkg.sv
// Shared types and constants of the linear probe pointer map.
// Used by every module of the block but lppm_ram; depends on nothing else.

package lppm_pkg;

  // Table geometry. CAPACITY must be a power of two.
  localparam int unsigned CAPACITY   = 64;
  localparam int unsigned SLOT_W     = $clog2(CAPACITY);
  localparam int unsigned CNT_W      = $clog2(CAPACITY + 1);
  // A new key is refused once the count reaches this limit.
  localparam int unsigned FULL_LIMIT = CAPACITY / 2 - 1;

  // Field widths.
  localparam int unsigned OP_W  = 2;
  localparam int unsigned KEY_W = 64;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned ST_W  = 2;

  // Stream data widths, padded to whole bytes.
  localparam int unsigned S_TDATA_W = KEY_W + VAL_W;
  localparam int unsigned RES_W     = 1 + VAL_W + ST_W;
  localparam int unsigned M_TDATA_W = ((RES_W + 7) / 8) * 8;

  // Hash constants.
  localparam logic [KEY_W-1:0] HASH_MULT  = 64'hff51afd7ed558ccd;
  localparam int unsigned      HASH_SHIFT = 33;

  // Command queue between front and back.
  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

  // Operation codes on the input tuser. Code three is a no-op.
  typedef enum logic [OP_W-1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_CLEAR  = 2'd2
  } op_e;

  // Result status codes.
  typedef enum logic [ST_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_ZERO_KEY = 2'd2
  } status_e;

  // Command kinds after classification in the front.
  typedef enum logic [2:0] {
    K_LOOKUP,
    K_INSERT,
    K_CLEAR,
    K_NOP,
    K_ZERO
  } kind_e;

  // Front state machine.
  typedef enum logic [2:0] {
    F_IDLE,
    F_MUL0,
    F_MUL1,
    F_MUL2,
    F_PUSH
  } front_state_e;

  // Back state machine.
  typedef enum logic {
    B_IDLE,
    B_PROBE
  } back_state_e;

  // One classified command.
  typedef struct packed {
    kind_e             kind;
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  value;
    logic [SLOT_W-1:0] home;
  } cmd_t;

  // One result.
  typedef struct packed {
    status_e          status;
    logic [VAL_W-1:0] value;
    logic             found;
  } res_t;

endpackage

// File: hw/rtl/linear_probe_pointer_map.sv
// Top level of the linear probe pointer map: a 64-bit key to 32-bit value hash map.
// Depends on lppm_pkg, lppm_front, lppm_fifo, lppm_back and lppm_ram.
//
//   channel | direction | tdata (low bit first)          | tuser
//   s_axis  | in        | key[63:0], value[95:64]        | operation[1:0]
//   m_axis  | out       | found[0], result_value[32:1],  | none
//           |           | status[34:33], zero[39:35]     |
//
// The front takes a new transaction only when idle or pushing, not while the 64-bit
// hash multiply of a lookup or insert runs as three steps of one shared 32x32
// multiplier. Clear, no-op and zero-key transactions skip the multiply and go to push.
// The back reads the home slot to start a probe and then steps one slot at a time,
// since the key and value memories each deliver one slot per cycle.
// Reset clears all valid bits and the entry count at once; no clearing pass.
// A two-entry command queue lets the front keep accepting while the back
// waits on a stalled output register.

module linear_probe_pointer_map (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // key [63:0], value [95:64]
  input  logic [lppm_pkg::S_TDATA_W-1:0] s_axis_tdata_i,
  // operation [1:0]
  input  logic [lppm_pkg::OP_W-1:0]      s_axis_tuser_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // found [0], result_value [32:1], status [34:33], zero padding above
  output logic [lppm_pkg::M_TDATA_W-1:0] m_axis_tdata_o
);

  lppm_pkg::cmd_t push_cmd, head_cmd;
  lppm_pkg::res_t res;
  logic push, full, pop, empty;

  lppm_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .s_op_i    (s_axis_tuser_i),
    .s_key_i   (s_axis_tdata_i[lppm_pkg::KEY_W-1:0]),
    .s_value_i (s_axis_tdata_i[lppm_pkg::KEY_W +: lppm_pkg::VAL_W]),
    .push_o    (push),
    .cmd_o     (push_cmd),
    .full_i    (full)
  );

  lppm_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .cmd_o   (head_cmd),
    .empty_o (empty)
  );

  lppm_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (head_cmd),
    .empty_i   (empty),
    .pop_o     (pop),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .m_res_o   (res)
  );

  // Pack the result, first field in the lowest bits.
  assign m_axis_tdata_o = {{(lppm_pkg::M_TDATA_W - lppm_pkg::RES_W){1'b0}},
                           res.status, res.value, res.found};

endmodule

// File: hw/rtl/lppm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Stand-alone; used by the probe engine for slot keys and slot values.

module lppm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/lppm_front.sv
// Front part: accepts input transactions, classifies them and hashes the key.
// Depends on lppm_pkg; feeds the command queue.

module lppm_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_valid_i,
  output logic                           s_ready_o,
  input  logic [lppm_pkg::OP_W-1:0]      s_op_i,
  input  logic [lppm_pkg::KEY_W-1:0]     s_key_i,
  input  logic [lppm_pkg::VAL_W-1:0]     s_value_i,
  output logic                           push_o,
  output lppm_pkg::cmd_t                 cmd_o,
  input  logic                           full_i
);

  lppm_pkg::front_state_e state_q, state_d;
  lppm_pkg::kind_e        kind_q, kind_in;
  logic [lppm_pkg::KEY_W-1:0] key_q, x1_q, acc_q, acc_d;
  logic [lppm_pkg::VAL_W-1:0] value_q;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic        accept, needs_hash;

  // Classify the incoming operation.
  always_comb begin
    case (s_op_i)
      lppm_pkg::OP_LOOKUP: begin
        kind_in = (s_key_i == '0) ? lppm_pkg::K_ZERO : lppm_pkg::K_LOOKUP;
      end
      lppm_pkg::OP_INSERT: begin
        kind_in = (s_key_i == '0) ? lppm_pkg::K_ZERO : lppm_pkg::K_INSERT;
      end
      lppm_pkg::OP_CLEAR: begin
        kind_in = lppm_pkg::K_CLEAR;
      end
      default: begin
        kind_in = lppm_pkg::K_NOP;
      end
    endcase
  end

  assign needs_hash = (kind_in == lppm_pkg::K_LOOKUP) || (kind_in == lppm_pkg::K_INSERT);
  assign accept     = s_valid_i && s_ready_o;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      lppm_pkg::F_IDLE: begin
        if (s_valid_i) begin
          state_d = needs_hash ? lppm_pkg::F_MUL0 : lppm_pkg::F_PUSH;
        end
      end
      lppm_pkg::F_MUL0: state_d = lppm_pkg::F_MUL1;
      lppm_pkg::F_MUL1: state_d = lppm_pkg::F_MUL2;
      lppm_pkg::F_MUL2: state_d = lppm_pkg::F_PUSH;
      lppm_pkg::F_PUSH: begin
        if (!full_i) begin
          if (s_valid_i) begin
            state_d = needs_hash ? lppm_pkg::F_MUL0 : lppm_pkg::F_PUSH;
          end else begin
            state_d = lppm_pkg::F_IDLE;
          end
        end
      end
      default: state_d = lppm_pkg::F_IDLE;
    endcase
  end

  // Outputs and multiplier operand selection.
  always_comb begin
    s_ready_o = 1'b0;
    push_o    = 1'b0;
    mul_a     = x1_q[31:0];
    mul_b     = lppm_pkg::HASH_MULT[31:0];
    case (state_q)
      lppm_pkg::F_IDLE: s_ready_o = 1'b1;
      lppm_pkg::F_MUL1: mul_b = lppm_pkg::HASH_MULT[63:32];
      lppm_pkg::F_MUL2: mul_a = x1_q[63:32];
      lppm_pkg::F_PUSH: begin
        s_ready_o = !full_i;
        push_o    = !full_i;
      end
      default: begin
      end
    endcase
  end

  // One shared 32x32 multiplier builds the 64-bit product in three steps.
  assign mul_p = mul_a * mul_b;

  always_comb begin
    acc_d = acc_q;
    case (state_q)
      lppm_pkg::F_MUL0: acc_d = mul_p;
      lppm_pkg::F_MUL1, lppm_pkg::F_MUL2: begin
        acc_d[63:32] = acc_q[63:32] + mul_p[31:0];
      end
      default: begin
      end
    endcase
  end

  // Home slot is the low bits of the final xor-shift.
  assign cmd_o.kind  = kind_q;
  assign cmd_o.key   = key_q;
  assign cmd_o.value = value_q;
  assign cmd_o.home  = acc_q[lppm_pkg::SLOT_W-1:0]
                     ^ acc_q[lppm_pkg::HASH_SHIFT +: lppm_pkg::SLOT_W];

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lppm_pkg::F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q  <= kind_in;
      key_q   <= s_key_i;
      value_q <= s_value_i;
      x1_q    <= s_key_i ^ (s_key_i >> lppm_pkg::HASH_SHIFT);
    end
    acc_q <= acc_d;
  end

  // The input is never taken while the multiplier is busy.
  a_no_accept_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lppm_pkg::F_MUL0 || state_q == lppm_pkg::F_MUL1 ||
     state_q == lppm_pkg::F_MUL2) |-> !s_ready_o)
    else $error("front accepted a transaction while hashing");

  // The three multiply steps run in consecutive cycles.
  a_mul_to_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lppm_pkg::F_MUL0) |=> ##1 (state_q == lppm_pkg::F_MUL2))
    else $error("front multiply sequence broken");

endmodule

// File: hw/rtl/lppm_fifo.sv
// Short command queue between the front and the probe engine.
// Depends on lppm_pkg for the command type and depth.

module lppm_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  lppm_pkg::cmd_t cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output lppm_pkg::cmd_t cmd_o,
  output logic           empty_o
);

  lppm_pkg::cmd_t mem_q [lppm_pkg::FIFO_DEPTH];
  logic [lppm_pkg::FIFO_AW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [lppm_pkg::FIFO_AW:0]   cnt_q, cnt_d;
  logic do_push, do_pop;

  assign full_o  = (cnt_q == (lppm_pkg::FIFO_AW+1)'(lppm_pkg::FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cmd_o   = mem_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = do_push ? lppm_pkg::FIFO_AW'(wr_ptr_q + 1'b1) : wr_ptr_q;
    rd_ptr_d = do_pop  ? lppm_pkg::FIFO_AW'(rd_ptr_q + 1'b1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("command queue pushed while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("command queue popped while empty");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (lppm_pkg::FIFO_AW+1)'(lppm_pkg::FIFO_DEPTH))
    else $error("command queue count out of range");

endmodule

// File: hw/rtl/lppm_back.sv
// Back part: the probe engine that walks the slot table and builds results.
// Depends on lppm_pkg and lppm_ram; drives the output register.

module lppm_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  lppm_pkg::cmd_t                  cmd_i,
  input  logic                            empty_i,
  output logic                            pop_o,
  output logic                            m_valid_o,
  input  logic                            m_ready_i,
  output lppm_pkg::res_t                  m_res_o
);

  lppm_pkg::back_state_e state_q, state_d;
  lppm_pkg::cmd_t        cur_q, cur_d;
  logic [lppm_pkg::SLOT_W-1:0]   idx_q, idx_d, n_q, n_d, raddr;
  logic [lppm_pkg::CAPACITY-1:0] valid_q, valid_d;
  logic [lppm_pkg::CNT_W-1:0]    count_q, count_d;
  logic                          out_valid_q, out_valid_d;
  lppm_pkg::res_t                out_q, res;
  logic [lppm_pkg::KEY_W-1:0]    key_rd;
  logic [lppm_pkg::VAL_W-1:0]    val_rd;
  logic out_free, slot_valid, hit, miss_empty, done, tbl_full, load_out;
  logic key_we, val_we, is_probe;

  // Slot storage.
  lppm_ram #(.WIDTH(lppm_pkg::KEY_W), .DEPTH(lppm_pkg::CAPACITY)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (idx_q),
    .wdata_i (cur_q.key),
    .raddr_i (raddr),
    .rdata_o (key_rd)
  );

  lppm_ram #(.WIDTH(lppm_pkg::VAL_W), .DEPTH(lppm_pkg::CAPACITY)) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (val_we),
    .waddr_i (idx_q),
    .wdata_i (cur_q.value),
    .raddr_i (raddr),
    .rdata_o (val_rd)
  );

  // Probe status for the slot whose data is on the RAM outputs.
  assign out_free   = !out_valid_q || m_ready_i;
  assign slot_valid = valid_q[idx_q];
  assign hit        = slot_valid && (key_rd == cur_q.key);
  assign miss_empty = !slot_valid;
  assign done       = hit || miss_empty || (n_q == {lppm_pkg::SLOT_W{1'b1}});
  assign tbl_full   = (count_q >= lppm_pkg::CNT_W'(lppm_pkg::FULL_LIMIT));
  assign is_probe   = (cmd_i.kind == lppm_pkg::K_LOOKUP) ||
                      (cmd_i.kind == lppm_pkg::K_INSERT);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      lppm_pkg::B_IDLE: begin
        if (!empty_i && is_probe) begin
          state_d = lppm_pkg::B_PROBE;
        end
      end
      lppm_pkg::B_PROBE: begin
        if (done && out_free) begin
          state_d = lppm_pkg::B_IDLE;
        end
      end
      default: state_d = lppm_pkg::B_IDLE;
    endcase
  end

  // Outputs, table updates and result selection.
  always_comb begin
    pop_o    = 1'b0;
    load_out = 1'b0;
    key_we   = 1'b0;
    val_we   = 1'b0;
    cur_d    = cur_q;
    idx_d    = idx_q;
    n_d      = n_q;
    valid_d  = valid_q;
    count_d  = count_q;
    raddr    = idx_q;
    res.found  = 1'b0;
    res.value  = '0;
    res.status = lppm_pkg::ST_OK;
    case (state_q)
      lppm_pkg::B_IDLE: begin
        raddr = cmd_i.home;
        if (!empty_i) begin
          if (is_probe) begin
            pop_o = 1'b1;
            cur_d = cmd_i;
            idx_d = cmd_i.home;
            n_d   = '0;
          end else if (out_free) begin
            pop_o    = 1'b1;
            load_out = 1'b1;
            if (cmd_i.kind == lppm_pkg::K_CLEAR) begin
              valid_d = '0;
              count_d = '0;
            end
            if (cmd_i.kind == lppm_pkg::K_ZERO) begin
              res.status = lppm_pkg::ST_ZERO_KEY;
            end
          end
        end
      end
      lppm_pkg::B_PROBE: begin
        if (!done) begin
          // Step to the next slot and fetch it.
          idx_d = lppm_pkg::SLOT_W'(idx_q + 1'b1);
          n_d   = lppm_pkg::SLOT_W'(n_q + 1'b1);
          raddr = idx_d;
        end else if (out_free) begin
          load_out  = 1'b1;
          res.found = hit;
          if (cur_q.kind == lppm_pkg::K_LOOKUP) begin
            if (hit) begin
              res.value = val_rd;
            end
          end else if (hit) begin
            val_we = 1'b1;
          end else if (miss_empty && !tbl_full) begin
            key_we         = 1'b1;
            val_we         = 1'b1;
            valid_d[idx_q] = 1'b1;
            count_d        = lppm_pkg::CNT_W'(count_q + 1'b1);
          end else begin
            res.status = lppm_pkg::ST_FULL;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_d = load_out || (out_valid_q && !m_ready_i);
  assign m_valid_o   = out_valid_q;
  assign m_res_o     = out_q;

  // Control state, occupancy and entry count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lppm_pkg::B_IDLE;
      valid_q     <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    idx_q <= idx_d;
    n_q   <= n_d;
    if (load_out) begin
      out_q <= res;
    end
  end

  // The entry count always matches the number of occupied slots.
  a_count_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == int'(count_q))
    else $error("entry count disagrees with occupancy");

  // At least half of the table stays empty.
  a_half_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= lppm_pkg::CNT_W'(lppm_pkg::FULL_LIMIT))
    else $error("entry count passed the fill limit");

  // A new key is always written with its value into an empty slot.
  a_new_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_we |-> (val_we && !slot_valid && !tbl_full))
    else $error("bad new key write");

  // An unfinished probe moves to the next slot.
  a_probe_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lppm_pkg::B_PROBE && !done) |=>
      (idx_q == lppm_pkg::SLOT_W'($past(idx_q) + 1'b1)))
    else $error("probe did not advance");

endmodule
